>>> hdl/base64_credential_validator_top_defines.svh
// ---------------------------------------------------------------------------
// base64_credential_validator_top_defines.svh
// Assertion macros for the base64 credential validator.
// ---------------------------------------------------------------------------
`ifndef BASE64_CREDENTIAL_VALIDATOR_TOP_DEFINES_SVH
`define BASE64_CREDENTIAL_VALIDATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64CV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("b64cv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64CV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("b64cv assertion failed");

`endif

>>> hdl/b64cv_pkg.sv
// ---------------------------------------------------------------------------
// b64cv_pkg
// Shared types and constants of the base64 credential validator.
// ---------------------------------------------------------------------------
`default_nettype none

package b64cv_pkg;

	typedef enum logic [1:0] {
		ACT_ANCHOR = 2'd0,
		ACT_TEXT   = 2'd1,
		ACT_END    = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_MIN_RUN        = 2'd0,
		REG_MAX_RUN        = 2'd1,
		REG_ANCHOR_IS_WORD = 2'd2
	} reg_index_t;

	localparam int unsigned RUN_W = 10;

	localparam logic [RUN_W-1:0] MIN_RUN_RESET = 10'd8;
	localparam logic [RUN_W-1:0] MAX_RUN_RESET = 10'd200;

	localparam logic [7:0] CH_PAD     = 8'h3D;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_HI   = 8'h7E;

	// Classification of one byte against both base64 alphabets.
	typedef struct packed {
		logic       is_sym;
		logic       is_pad;
		logic       is_word;
		logic [5:0] value;
	} sym_info_t;

endpackage

`default_nettype wire

>>> hdl/base64_credential_validator_top.sv
// ---------------------------------------------------------------------------
// base64_credential_validator_top
// Checks that a base64 run after an anchor decodes to a printable user:pass.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  -----------------------------------
//  in       sink       in_valid / in_stall   action, byte_value, preceding_byte,
//                                            at_text_start
//  out      source     out_valid / out_stall accepted, run_length
//  cfg      sink       cfg_we                cfg_index, cfg_data
//
//  One item a cycle while in_stall is low: each item is decoded and folded
//  into the run state in the cycle it is accepted, and any verdict is
//  registered in the output register, or in the skid while the output is held.
//  The output register is backed by a one-entry skid stage, so input keeps
//  flowing while a verdict waits; in_stall rises only when the skid is full.
//  Reset clears all run state and loads the register defaults.
//
`default_nettype none

`include "base64_credential_validator_top_defines.svh"

module base64_credential_validator_top #(
	parameter int unsigned DECODE_LIMIT = 96
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      action,
	input  wire logic [7:0]                      byte_value,
	input  wire logic [7:0]                      preceding_byte,
	input  wire logic                            at_text_start,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 accepted,
	output logic [b64cv_pkg::RUN_W-1:0]          run_length,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [b64cv_pkg::RUN_W-1:0]     cfg_data
);

	localparam int unsigned DEC_W = $clog2(DECODE_LIMIT + 1);
	localparam logic [DEC_W-1:0] DEC_LIMIT = DEC_W'(DECODE_LIMIT);
	localparam logic [DEC_W-1:0] DEC_MIN   = DEC_W'(2);

	// configuration registers
	logic [b64cv_pkg::RUN_W-1:0] min_run_q;
	logic [b64cv_pkg::RUN_W-1:0] max_run_q;
	logic                        anchor_word_q;

	// run state
	logic                        active_q;
	logic [b64cv_pkg::RUN_W-1:0] run_cnt_q;
	logic [11:0]                 acc_q;
	logic [2:0]                  pend_q;
	logic [DEC_W-1:0]            dec_cnt_q;
	logic                        colon_q;
	logic                        bad_q;
	logic                        stopped_q;

	// output register and skid stage
	logic                        out_valid_q;
	logic                        out_ok_q;
	logic [b64cv_pkg::RUN_W-1:0] out_len_q;
	logic                        skid_valid_q;
	logic                        skid_ok_q;
	logic [b64cv_pkg::RUN_W-1:0] skid_len_q;

	b64cv_pkg::sym_info_t        txt_info;
	b64cv_pkg::sym_info_t        prev_info;

	logic                        in_acc;
	logic                        out_take;
	b64cv_pkg::action_t          act;

	// next-state values
	logic                        emit;
	logic                        fail;
	logic                        clear;
	logic                        open_run;
	logic [b64cv_pkg::RUN_W-1:0] n_run;
	logic [11:0]                 n_acc;
	logic [2:0]                  n_pend;
	logic [DEC_W-1:0]            n_dec;
	logic                        n_colon;
	logic                        n_bad;
	logic                        n_stop;
	logic [7:0]                  dec_byte;
	logic                        dec_out;
	logic                        v_ok;
	logic [b64cv_pkg::RUN_W-1:0] v_len;

	b64cv_sym_decode u_txt_dec (
		.byte_in (byte_value),
		.info    (txt_info)
	);

	b64cv_sym_decode u_prev_dec (
		.byte_in (preceding_byte),
		.info    (prev_info)
	);

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid & ~skid_valid_q;
	assign out_take = out_valid_q & ~out_stall;
	assign act      = b64cv_pkg::action_t'(action);

	// Fold one item into the run state and decide whether it ends the run.
	always_comb begin
		emit     = 1'b0;
		fail     = 1'b0;
		clear    = 1'b0;
		open_run = 1'b0;
		n_run    = run_cnt_q;
		n_acc    = acc_q;
		n_pend   = pend_q;
		n_dec    = dec_cnt_q;
		n_colon  = colon_q;
		n_bad    = bad_q;
		n_stop   = stopped_q;
		dec_byte = acc_q[7:0];
		dec_out  = 1'b0;

		if (in_acc) begin
			unique case (act)
				b64cv_pkg::ACT_ANCHOR: begin
					// any open run is dropped silently
					clear = 1'b1;
					if (anchor_word_q && !at_text_start && prev_info.is_word) begin
						emit = 1'b1;
						fail = 1'b1;
					end else begin
						open_run = 1'b1;
					end
				end
				b64cv_pkg::ACT_END: begin
					emit = active_q;
				end
				b64cv_pkg::ACT_TEXT: begin
					if (active_q) begin
						priority if (run_cnt_q >= max_run_q) begin
							// limit already met: give the verdict, byte unused
							emit = 1'b1;
						end else if (!txt_info.is_sym && !txt_info.is_pad) begin
							// foreign byte closes the run
							emit = 1'b1;
						end else begin
							n_run = run_cnt_q + 1'b1;
							if (!stopped_q && (dec_cnt_q < DEC_LIMIT)) begin
								if (txt_info.is_pad) begin
									n_stop = 1'b1;
								end else begin
									n_acc = {acc_q[5:0], txt_info.value};
									unique case (pend_q)
										3'd2: begin
											n_pend   = 3'd0;
											dec_byte = n_acc[7:0];
											dec_out  = 1'b1;
										end
										3'd4: begin
											n_pend   = 3'd2;
											dec_byte = n_acc[9:2];
											dec_out  = 1'b1;
										end
										3'd6: begin
											n_pend   = 3'd4;
											dec_byte = n_acc[11:4];
											dec_out  = 1'b1;
										end
										default: begin
											n_pend = 3'd6;
										end
									endcase
									if (dec_out) begin
										n_dec = dec_cnt_q + 1'b1;
										if (dec_byte < b64cv_pkg::PRINT_LO ||
											dec_byte > b64cv_pkg::PRINT_HI) begin
											n_bad = 1'b1;
										end
										if (dec_byte == b64cv_pkg::CH_COLON) begin
											n_colon = 1'b1;
										end
									end
								end
							end
							if (n_run >= max_run_q) begin
								emit = 1'b1;
							end
						end
					end
				end
				default: begin
					// unused action code: ignore
				end
			endcase
		end

		v_ok  = !fail && (n_run >= min_run_q) && (n_dec >= DEC_MIN) && n_colon && !n_bad;
		v_len = v_ok ? n_run : '0;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q     <= b64cv_pkg::MIN_RUN_RESET;
			max_run_q     <= b64cv_pkg::MAX_RUN_RESET;
			anchor_word_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (b64cv_pkg::reg_index_t'(cfg_index))
				b64cv_pkg::REG_MIN_RUN:        min_run_q     <= cfg_data;
				b64cv_pkg::REG_MAX_RUN:        max_run_q     <= cfg_data;
				b64cv_pkg::REG_ANCHOR_IS_WORD: anchor_word_q <= cfg_data[0];
				default: begin
					// write beyond the register list: drop
				end
			endcase
		end
	end

	// run state: clear on a verdict or an anchor, else advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			run_cnt_q <= '0;
			acc_q     <= '0;
			pend_q    <= '0;
			dec_cnt_q <= '0;
			colon_q   <= 1'b0;
			bad_q     <= 1'b0;
			stopped_q <= 1'b0;
		end else if (emit || clear) begin
			active_q  <= open_run;
			run_cnt_q <= '0;
			acc_q     <= '0;
			pend_q    <= '0;
			dec_cnt_q <= '0;
			colon_q   <= 1'b0;
			bad_q     <= 1'b0;
			stopped_q <= 1'b0;
		end else begin
			run_cnt_q <= n_run;
			acc_q     <= n_acc;
			pend_q    <= n_pend;
			dec_cnt_q <= n_dec;
			colon_q   <= n_colon;
			bad_q     <= n_bad;
			stopped_q <= n_stop;
		end
	end

	// Output register with skid. A new verdict goes to the output register
	// when that is free (or being taken with nothing in the skid), else to
	// the skid; a taken output refills from the skid first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (emit) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_ok_q  <= skid_ok_q;
				out_len_q <= skid_len_q;
			end
		end else if (emit) begin
			if (!out_valid_q || out_take) begin
				out_ok_q  <= v_ok;
				out_len_q <= v_len;
			end else begin
				skid_ok_q  <= v_ok;
				skid_len_q <= v_len;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = out_ok_q;
	assign run_length = out_len_q;

	// the skid only fills behind a held output
	`B64CV_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	// decoding stops at the limit
	`B64CV_ASSERT_NOW(a_dec_bounded, clk, arst_n, 1'b1, dec_cnt_q <= DEC_LIMIT)
	// an idle block carries no leftover run
	`B64CV_ASSERT_NOW(a_idle_clear, clk, arst_n, !active_q,
		run_cnt_q == '0 && dec_cnt_q == '0 && pend_q == '0)
	// a verdict always reaches a register in the next cycle
	`B64CV_ASSERT_NEXT(a_emit_lands, clk, arst_n, emit, out_valid_q)

endmodule

`default_nettype wire

>>> hdl/b64cv_sym_decode.sv
// ---------------------------------------------------------------------------
// b64cv_sym_decode
// Classify a byte: base64 symbol value (standard or URL), pad, word char.
// ---------------------------------------------------------------------------
`default_nettype none

module b64cv_sym_decode (
	input  wire logic [7:0]          byte_in,
	output b64cv_pkg::sym_info_t     info
);

	logic is_upper;
	logic is_lower;
	logic is_digit;
	logic is_62;
	logic is_63;
	logic [7:0] val8;

	assign is_upper = (byte_in >= 8'h41) && (byte_in <= 8'h5A);
	assign is_lower = (byte_in >= 8'h61) && (byte_in <= 8'h7A);
	assign is_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
	assign is_62    = (byte_in == 8'h2B) || (byte_in == 8'h2D);
	assign is_63    = (byte_in == 8'h2F) || (byte_in == 8'h5F);

	always_comb begin
		priority if (is_upper) begin
			val8 = byte_in - 8'd65;
		end else if (is_lower) begin
			val8 = byte_in - 8'd71;
		end else if (is_digit) begin
			val8 = byte_in + 8'd4;
		end else if (is_62) begin
			val8 = 8'd62;
		end else begin
			val8 = 8'd63;
		end
	end

	assign info.is_sym  = is_upper | is_lower | is_digit | is_62 | is_63;
	assign info.is_pad  = (byte_in == b64cv_pkg::CH_PAD);
	// word characters: letters, digits and underscore
	assign info.is_word = is_upper | is_lower | is_digit | (byte_in == 8'h5F);
	assign info.value   = val8[5:0];

endmodule

`default_nettype wire
